// ----- rtl/ssq_pkg.sv -----
// Shared types and constants for the set successor query block.
package ssq_pkg;

    // Default number of entries in the stored set.
    localparam int SET_DEPTH_DEF = 64;

    // Width of one stored value.
    localparam int VALUE_W = 32;

    // One incoming request.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      start_req;
    } req_t;

    // One result.
    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] successor;
        logic                      overflow;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new request and restart the scan
        logic scan;    // step the scan through the stored entries
        logic commit;  // insert the value and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

// ----- rtl/ssq_ctrl.sv -----
// Controller state machine for the set successor query block.
module ssq_ctrl
    import ssq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Commands follow from the current state and the handshakes.
    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && req_valid;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.commit = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);
    end

    // Next state and result valid.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- rtl/ssq_datapath.sv -----
// Datapath: set memory, entry count, scan compare and result register.
module ssq_datapath
    import ssq_pkg::*;
#(
    parameter int SET_DEPTH = SET_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output sts_t sts,
    input  req_t req_data,
    output rsp_t rsp_data
);

    localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W = $clog2(SET_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SET_DEPTH);

    // Stored values; only entries below the count are ever read.
    logic signed [VALUE_W-1:0] mem [SET_DEPTH];

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          rd_idx_reg;
    logic [CNT_W-1:0]          rd_idx_next;
    logic                      rd_vld_reg;
    logic                      rd_vld_next;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      have_reg;
    logic                      have_next;
    logic                      present_reg;
    logic                      present_next;
    logic signed [VALUE_W-1:0] best_reg;
    logic signed [VALUE_W-1:0] best_next;
    rsp_t                      rsp_reg;
    logic                      rd_en;
    logic                      wr_en;
    logic                      not_full;

    assign not_full = (count_reg < DEPTH_CNT);
    assign rd_en    = cmd.scan && (rd_idx_reg < count_reg);
    assign wr_en    = cmd.commit && !present_reg && not_full;

    // The scan is over once every entry was read and the last one compared.
    assign sts.scan_done = (rd_idx_reg == count_reg) && !rd_vld_reg;

    // Scan bookkeeping and the running minimum over greater entries.
    always_comb
    begin
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        rd_vld_next  = rd_en;
        have_next    = have_reg;
        present_next = present_reg;
        best_next    = best_reg;

        if (cmd.load)
        begin
            rd_idx_next  = '0;
            rd_vld_next  = 1'b0;
            have_next    = 1'b0;
            present_next = 1'b0;
            if (req_data.start_req)
            begin
                count_next = '0;
            end
        end
        else
        begin
            if (rd_en)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            if (rd_vld_reg)
            begin
                if (rd_data_reg == value_reg)
                begin
                    present_next = 1'b1;
                end
                else if ((rd_data_reg > value_reg) && (!have_reg || (rd_data_reg < best_reg)))
                begin
                    have_next = 1'b1;
                    best_next = rd_data_reg;
                end
            end
            if (wr_en)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            have_reg    <= 1'b0;
            present_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            rd_vld_reg  <= rd_vld_next;
            have_reg    <= have_next;
            present_reg <= present_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (cmd.load)
        begin
            value_reg <= req_data.value;
        end
        if (cmd.commit)
        begin
            rsp_reg.found     <= have_reg;
            rsp_reg.successor <= have_reg ? best_reg : '0;
            rsp_reg.overflow  <= !present_reg && !not_full;
        end
    end

    // Set memory: one read port with registered data, one write port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= value_reg;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

// ----- rtl/set_successor_query.sv -----
// Top level of the set successor query block.
// Each request carries a signed 32-bit value; the block answers with the least
// stored value strictly greater than it (found = 0 and successor = 0 if none),
// then adds the value to the set unless it is already there. A set start flag
// empties the set first; a new value arriving at a full set is dropped and
// flagged as overflow. A request occupies the block through these steps, in order:
// it is accepted; the scan reads the stored entries, one entry a cycle through
// the single read port of the set memory; the last entry read is compared; the
// controller sees that the scan is over; and the value is inserted and the
// result loaded, which waits while an earlier result is still stalled at the
// output. The result sits in an output register, so the next request can be
// taken while it waits to be collected.
module set_successor_query
    import ssq_pkg::*;
#(
    parameter int SET_DEPTH = SET_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    ssq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage and compare logic.
    ssq_datapath #(
        .SET_DEPTH (SET_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule

// ----- rtl/ssq_checker.sv -----
// Port-level checks for the set successor query block, bound to the top level.
module ssq_checker
    import ssq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req_data,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_data
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

    // A stalled request stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
    else $error("stalled request changed");

    // A result without a successor reports zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.found |-> rsp_data.successor == '0)
    else $error("successor not zero when not found");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request accepted while busy");

    // A fresh result never shows up in the cycle right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
    else $error("result appeared too early");

endmodule

bind set_successor_query ssq_checker u_ssq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
